[src/lgi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared constants and the sequencer state type of the Lagrange grid
// interpolator.
// ----------------------------------------------------------------------------
package lgi_pkg;

   localparam int DEF_GRID_DEPTH = 256;
   // width of the exact integer datapath (products, quotients, sum of terms)
   localparam int WIDE           = 160;
   localparam int GUARD_BITS     = 8;
   localparam int SLOPE_SHIFT    = 24;
   localparam logic [8:0] PTS_RESET = 9'd256;
   localparam logic [8:0] PTS_MIN   = 9'd4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SRCH_ADDR,
      ST_SRCH_DATA,
      ST_PICK,
      ST_LD_ADDR,
      ST_LD_DATA,
      ST_TERM,
      ST_PASS,
      ST_FACT,
      ST_MUL,
      ST_FACT_END,
      ST_NUM_ADD,
      ST_NUM_MAG,
      ST_YMUL,
      ST_SCALE,
      ST_DIV,
      ST_ACC,
      ST_NEXT_K,
      ST_FINAL
   } lgi_state_type;

endpackage
`default_nettype wire

[src/lagrange_grid_interpolator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lagrange_grid_interpolator_core
// Nonuniform-grid Lagrange interpolator (3 or 4 points), signed Q16.16,
// value or slope, exact integer arithmetic on one shared adder.
// ----------------------------------------------------------------------------
// A write request stores one grid point. A query scans the first
// points_in_use grid entries (one memory read and compare per grid entry, in
// an address state and a data state), loads each used point through the same
// two states, then for each Lagrange term builds every factor (a dispatch
// state plus the serial shift-add multiplier) and ends with a restoring
// division. A zero divisor skips the rest of its term and shortens the query.
// Every multiply, divide step, accumulate and round shares a single 161-bit
// adder; the block takes no new request until the result register has been
// loaded. The grid memories have no reset and need no clearing.
// ----------------------------------------------------------------------------
module lagrange_grid_interpolator_core #(
   parameter int GRID_DEPTH = lgi_pkg::DEF_GRID_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] point_index, [39:8] grid_abscissa, [71:40] grid_ordinate,
   // [103:72] query_x, [104] want_slope
   input  logic [111:0] req_tdata,
   // [0] cmd
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] result_value, [32] overflow
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [8:0]   csr_data
);
   import lgi_pkg::*;

   localparam int AW  = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
   localparam int CW  = $clog2(GRID_DEPTH + 1);
   localparam int DCW = $clog2(WIDE);

   logic               cmd;
   logic [7:0]         point_index;
   logic signed [31:0] grid_abscissa, grid_ordinate, query_x;
   logic               want_slope;

   assign cmd           = req_tuser[0];
   assign point_index   = req_tdata[7:0];
   assign grid_abscissa = req_tdata[39:8];
   assign grid_ordinate = req_tdata[71:40];
   assign query_x       = req_tdata[103:72];
   assign want_slope    = req_tdata[104];

   lgi_state_type state_ff, state_in, ret_ff, ret_in;
   logic [8:0]         pts_ff, pts_in;
   logic signed [31:0] qx_ff, qx_in, prev_ff, prev_in;
   logic               slope_ff, slope_in;
   logic [CW-1:0]      i_ff, i_in, fidx_ff, fidx_in, p0_ff, p0_in;
   logic               lt0_ff, lt0_in, ge_ff, ge_in, found_ff, found_in, n4_ff, n4_in;
   logic [1:0]         q_ff, q_in, kc_ff, kc_in, mpos_ff, mpos_in;
   logic [2:0]         jpos_ff, jpos_in;
   logic signed [31:0] xs_ff [4], xs_in [4], ys_ff [4], ys_in [4];
   logic signed [31:0] fq_ff [3], fq_in [3];
   logic               phase_ff, phase_in, psign_ff, psign_in, dsign_ff, dsign_in;
   logic [WIDE-1:0]    prod_ff, prod_in, shift_ff, shift_in, den_ff, den_in;
   logic [WIDE-1:0]    numacc_ff, numacc_in, acc_ff, acc_in, rem_ff, rem_in;
   logic [31:0]        fact_ff, fact_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic               div0_ff, div0_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_ov_ff, rsp_ov_in;
   logic [31:0]        rsp_val_ff, rsp_val_in;

   // grid memories
   logic signed [31:0] abs_mem [GRID_DEPTH];
   logic signed [31:0] ord_mem [GRID_DEPTH];
   logic signed [31:0] rd_ax_ff, rd_ay_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               mem_we;

   assign mem_we  = req_tvalid && req_tready && (cmd == CMD_WRITE)
                    && ({24'd0, point_index} < 32'(GRID_DEPTH));
   assign wr_addr = AW'({24'd0, point_index});

   always_ff @(posedge clock) begin
      if (mem_we) begin
         abs_mem[wr_addr] <= grid_abscissa;
         ord_mem[wr_addr] <= grid_ordinate;
      end
      rd_ax_ff <= abs_mem[rd_addr];
      rd_ay_ff <= ord_mem[rd_addr];
   end

   // clamp the point count into the usable range
   logic [CW-1:0] cnt;
   always_comb begin
      if (pts_ff < PTS_MIN) begin
         cnt = CW'(4);
      end else if (32'(pts_ff) > 32'(GRID_DEPTH)) begin
         cnt = CW'(GRID_DEPTH);
      end else begin
         cnt = CW'(pts_ff);
      end
   end

   // shared adder; sub gives a - b with carry out set when a >= b
   logic [WIDE-1:0] add_a, add_b;
   logic            add_sub;
   logic [WIDE:0]   add_res;
   assign add_res = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
                    + {{WIDE{1'b0}}, add_sub};

   // current factor: abscissa difference or query distance
   logic signed [32:0] fdiff;
   logic [32:0]        fneg;
   logic [31:0]        fmag, ymag;
   assign fdiff = phase_ff ? ({qx_ff[31], qx_ff} - {fq_ff[0][31], fq_ff[0]})
                           : ({xs_ff[0][31], xs_ff[0]} - {fq_ff[0][31], fq_ff[0]});
   assign fneg  = -fdiff;
   assign fmag  = fdiff[32] ? fneg[31:0] : fdiff[31:0];
   assign ymag  = ys_ff[0][31] ? (32'd0 - ys_ff[0]) : ys_ff[0];

   logic [2:0]         nlast;
   logic [1:0]         plast;
   logic [CW-1:0]      idx;
   logic [WIDE-1:0]    remsh;
   logic signed [WIDE-1:0] rnd, shr;
   logic [WIDE-32:0]   top;
   logic               fits;

   assign nlast = n4_ff ? 3'd4 : 3'd3;
   assign plast = n4_ff ? 2'd3 : 2'd2;
   assign remsh = {rem_ff[WIDE-2:0], prod_ff[WIDE-1]};
   assign rnd   = add_res[WIDE-1:0];
   assign shr   = rnd >>> GUARD_BITS;
   assign top   = shr[WIDE-1:31];
   assign fits  = (&top) | (~|top);

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  pts_in = pts_ff;
      qx_in = qx_ff;  slope_in = slope_ff;  prev_in = prev_ff;
      i_in = i_ff;  fidx_in = fidx_ff;  p0_in = p0_ff;
      lt0_in = lt0_ff;  ge_in = ge_ff;  found_in = found_ff;  n4_in = n4_ff;
      q_in = q_ff;  kc_in = kc_ff;  mpos_in = mpos_ff;  jpos_in = jpos_ff;
      xs_in = xs_ff;  ys_in = ys_ff;  fq_in = fq_ff;
      phase_in = phase_ff;  psign_in = psign_ff;  dsign_in = dsign_ff;
      prod_in = prod_ff;  shift_in = shift_ff;  den_in = den_ff;
      numacc_in = numacc_ff;  acc_in = acc_ff;  rem_in = rem_ff;
      fact_in = fact_ff;  dcnt_in = dcnt_ff;  div0_in = div0_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in = rsp_val_ff;  rsp_ov_in = rsp_ov_ff;
      add_a = '0;  add_b = '0;  add_sub = 1'b0;
      rd_addr = '0;
      idx = '0;
      req_tready = 1'b0;

      if (csr_valid) begin
         pts_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && cmd == CMD_QUERY) begin
               qx_in    = query_x;
               slope_in = want_slope;
               i_in     = '0;
               found_in = 1'b0;
               div0_in  = 1'b0;
               acc_in   = '0;
               state_in = ST_SRCH_ADDR;
            end
         end
         ST_SRCH_ADDR: begin
            rd_addr  = AW'(i_ff);
            state_in = ST_SRCH_DATA;
         end
         ST_SRCH_DATA: begin
            if (i_ff == '0) begin
               lt0_in = qx_ff < rd_ax_ff;
            end else if (prev_ff <= qx_ff && qx_ff < rd_ax_ff) begin
               found_in = 1'b1;
               fidx_in  = i_ff - CW'(1);
            end
            if (i_ff == cnt - CW'(1)) begin
               ge_in    = qx_ff >= rd_ax_ff;
               state_in = ST_PICK;
            end else begin
               prev_in  = rd_ax_ff;
               i_in     = i_ff + CW'(1);
               state_in = ST_SRCH_ADDR;
            end
         end
         ST_PICK: begin
            if (lt0_ff) begin
               idx = '0;
            end else if (ge_ff || !found_ff) begin
               idx = cnt - CW'(2);
            end else begin
               idx = fidx_ff;
            end
            if (idx == '0) begin
               p0_in = '0;
               n4_in = 1'b0;
            end else if (idx >= cnt - CW'(2)) begin
               p0_in = cnt - CW'(3);
               n4_in = 1'b0;
            end else begin
               p0_in = idx - CW'(1);
               n4_in = 1'b1;
            end
            q_in     = '0;
            state_in = ST_LD_ADDR;
         end
         ST_LD_ADDR: begin
            rd_addr  = AW'(p0_ff + CW'(q_ff));
            state_in = ST_LD_DATA;
         end
         ST_LD_DATA: begin
            xs_in[q_ff] = rd_ax_ff;
            ys_in[q_ff] = rd_ay_ff;
            if (q_ff == plast) begin
               kc_in    = '0;
               state_in = ST_TERM;
            end else begin
               q_in     = q_ff + 2'd1;
               state_in = ST_LD_ADDR;
            end
         end
         ST_TERM: begin
            // the current point sits at ring position 0; the others follow
            phase_in = 1'b0;
            prod_in  = WIDE'(1);
            psign_in = 1'b0;
            fq_in[0] = xs_ff[1];  fq_in[1] = xs_ff[2];  fq_in[2] = xs_ff[3];
            jpos_in  = 3'd1;
            state_in = ST_FACT;
         end
         ST_PASS: begin
            prod_in  = WIDE'(1);
            psign_in = 1'b0;
            fq_in[0] = xs_ff[1];  fq_in[1] = xs_ff[2];  fq_in[2] = xs_ff[3];
            jpos_in  = 3'd1;
            state_in = ST_FACT;
         end
         ST_FACT: begin
            if (jpos_ff == nlast) begin
               state_in = ST_FACT_END;
            end else begin
               fq_in[0] = fq_ff[1];
               fq_in[1] = fq_ff[2];
               jpos_in  = jpos_ff + 3'd1;
               // skip the factor left out of this derivative product
               if (!(phase_ff && {1'b0, mpos_ff} == jpos_ff)) begin
                  shift_in = prod_ff;
                  prod_in  = '0;
                  fact_in  = fmag;
                  psign_in = psign_ff ^ fdiff[32];
                  ret_in   = ST_FACT;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (fact_ff == '0) begin
               state_in = ret_ff;
            end else begin
               add_a = prod_ff;
               add_b = shift_ff;
               if (fact_ff[0]) begin
                  prod_in = add_res[WIDE-1:0];
               end
               shift_in = {shift_ff[WIDE-2:0], 1'b0};
               fact_in  = {1'b0, fact_ff[31:1]};
            end
         end
         ST_FACT_END: begin
            if (!phase_ff) begin
               den_in   = prod_ff;
               dsign_in = psign_ff;
               if (prod_ff == '0) begin
                  div0_in  = 1'b1;
                  state_in = ST_NEXT_K;
               end else begin
                  phase_in  = 1'b1;
                  numacc_in = '0;
                  mpos_in   = slope_ff ? 2'd1 : 2'd0;
                  state_in  = ST_PASS;
               end
            end else begin
               state_in = ST_NUM_ADD;
            end
         end
         ST_NUM_ADD: begin
            add_a     = numacc_ff;
            add_b     = prod_ff;
            add_sub   = psign_ff;
            numacc_in = add_res[WIDE-1:0];
            if (slope_ff && mpos_ff != plast) begin
               mpos_in  = mpos_ff + 2'd1;
               state_in = ST_PASS;
            end else begin
               state_in = ST_NUM_MAG;
            end
         end
         ST_NUM_MAG: begin
            add_a    = '0;
            add_b    = numacc_ff;
            add_sub  = 1'b1;
            prod_in  = numacc_ff[WIDE-1] ? add_res[WIDE-1:0] : numacc_ff;
            psign_in = numacc_ff[WIDE-1];
            state_in = ST_YMUL;
         end
         ST_YMUL: begin
            shift_in = prod_ff;
            prod_in  = '0;
            fact_in  = ymag;
            psign_in = psign_ff ^ ys_ff[0][31];
            ret_in   = ST_SCALE;
            state_in = ST_MUL;
         end
         ST_SCALE: begin
            prod_in  = slope_ff ? (prod_ff << SLOPE_SHIFT) : (prod_ff << GUARD_BITS);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            add_a   = remsh;
            add_b   = den_ff;
            add_sub = 1'b1;
            rem_in  = add_res[WIDE] ? add_res[WIDE-1:0] : remsh;
            prod_in = {prod_ff[WIDE-2:0], add_res[WIDE]};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(WIDE - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            add_a    = acc_ff;
            add_b    = prod_ff;
            add_sub  = psign_ff ^ dsign_ff;
            acc_in   = add_res[WIDE-1:0];
            state_in = ST_NEXT_K;
         end
         ST_NEXT_K: begin
            if (kc_ff == plast) begin
               state_in = ST_FINAL;
            end else begin
               kc_in = kc_ff + 2'd1;
               // rotate the ring of used points by one
               xs_in[0] = xs_ff[1];  ys_in[0] = ys_ff[1];
               xs_in[1] = xs_ff[2];  ys_in[1] = ys_ff[2];
               if (n4_ff) begin
                  xs_in[2] = xs_ff[3];  ys_in[2] = ys_ff[3];
                  xs_in[3] = xs_ff[0];  ys_in[3] = ys_ff[0];
               end else begin
                  xs_in[2] = xs_ff[0];  ys_in[2] = ys_ff[0];
               end
               state_in = ST_TERM;
            end
         end
         ST_FINAL: begin
            add_a = acc_ff;
            add_b = WIDE'(1 << (GUARD_BITS - 1));
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (div0_ff) begin
                  rsp_val_in = '0;
                  rsp_ov_in  = 1'b1;
               end else if (fits) begin
                  rsp_val_in = shr[31:0];
                  rsp_ov_in  = 1'b0;
               end else begin
                  rsp_val_in = shr[WIDE-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  rsp_ov_in  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pts_ff       <= PTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qx_ff <= qx_in;  slope_ff <= slope_in;  prev_ff <= prev_in;
      i_ff <= i_in;  fidx_ff <= fidx_in;  p0_ff <= p0_in;
      lt0_ff <= lt0_in;  ge_ff <= ge_in;  found_ff <= found_in;  n4_ff <= n4_in;
      q_ff <= q_in;  kc_ff <= kc_in;  mpos_ff <= mpos_in;  jpos_ff <= jpos_in;
      xs_ff <= xs_in;  ys_ff <= ys_in;  fq_ff <= fq_in;
      phase_ff <= phase_in;  psign_ff <= psign_in;  dsign_ff <= dsign_in;
      prod_ff <= prod_in;  shift_ff <= shift_in;  den_ff <= den_in;
      numacc_ff <= numacc_in;  acc_ff <= acc_in;  rem_ff <= rem_in;
      fact_ff <= fact_in;  dcnt_ff <= dcnt_in;  div0_ff <= div0_in;
      rsp_val_ff <= rsp_val_in;  rsp_ov_ff <= rsp_ov_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ov_ff, rsp_val_ff};

endmodule
`default_nettype wire
